FILE: hdl/brsc_pkg.sv
// brsc_pkg: shared field widths, codes and controller/datapath interface structs
// for the banker's request safety check. Depends on nothing.
`timescale 1ns / 1ps

package brsc_pkg;

  // input and output field widths
  localparam int FUNC_W      = 2;
  localparam int PROC_W      = 4;
  localparam int RES_W       = 3;
  localparam int VAL_W       = 8;
  localparam int VERDICT_W   = 2;
  localparam int COUNT_W     = 5;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 8;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 5;
  localparam int CFG_NP_W    = 5;
  localparam int CFG_NR_W    = 4;
  localparam logic [CFG_INDEX_W-1:0] CFG_NUM_PROC = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_NUM_RES  = 1'b1;
  localparam logic [CFG_NP_W-1:0]    CFG_NP_RESET = 5'd16;
  localparam logic [CFG_NR_W-1:0]    CFG_NR_RESET = 4'd8;

  // function codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD_ENTRY = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_AVAIL = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REQUEST    = 2'd2;

  // verdict codes
  localparam logic [VERDICT_W-1:0] VERDICT_GRANTED = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_EXCEEDS = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_UNSAFE  = 2'd2;

  // what a table read is used for once its data returns
  localparam logic [1:0] MODE_CHECK  = 2'd0;
  localparam logic [1:0] MODE_SCAN   = 2'd1;
  localparam logic [1:0] MODE_COMMIT = 2'd2;

  typedef struct packed {
    logic                 accept;
    logic                 fit_init;
    logic                 issue;
    logic [1:0]           mode;
    logic                 row_is_req;
    logic                 i_clr;
    logic                 i_inc;
    logic                 scan_init;
    logic                 pass_start;
    logic                 proc_done;
    logic                 avail_commit;
    logic                 out_load;
    logic [VERDICT_W-1:0] verdict;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_req;
    logic proc_bad;
    logic j_last;
    logic i_last;
    logic fit;
    logic found;
    logic all_done;
    logic finished_i;
    logic out_free;
  } ctrl_status_t;

endpackage

FILE: hdl/bankers_request_safety_check.sv
// bankers_request_safety_check: top level, joins brsc_ctrl and brsc_datapath (brsc_pkg).
// Loads and non-last request elements are taken while idle. A last element with an
// out-of-range process goes straight to an exceeds result; else the request is checked,
// then scanned in passes over the unfinished processes (finished ones are skipped),
// then committed if granted. Input waits until the result is registered.
// Reset (sync, active high) clears control, request and work state; tables need loading.
`timescale 1ns / 1ps

module bankers_request_safety_check #(
  parameter int MAX_PROCESSES = 16,
  parameter int MAX_RESOURCES = 8,
  parameter int UNIT_WIDTH    = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [brsc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [brsc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // process[3:0], resource[6:4], alloc_value[14:7], max_value[22:15],
  // amount[30:23], zero[31]
  input  logic [brsc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // func[1:0]
  input  logic [brsc_pkg::FUNC_W-1:0]          s_axis_tuser,
  input  logic                                 s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // verdict[1:0], finished_count[6:2], zero[7]
  output logic [brsc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
  import brsc_pkg::*;

  ctrl_cmd_t              cmd;
  ctrl_status_t           st;
  logic [VERDICT_W-1:0]   verdict;
  logic [COUNT_W-1:0]     finished_count;

  brsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  brsc_datapath #(
    .MAX_PROCESSES (MAX_PROCESSES),
    .MAX_RESOURCES (MAX_RESOURCES),
    .UNIT_WIDTH    (UNIT_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .func           (s_axis_tuser),
    .process        (s_axis_tdata[3:0]),
    .resource       (s_axis_tdata[6:4]),
    .alloc_value    (s_axis_tdata[14:7]),
    .max_value      (s_axis_tdata[22:15]),
    .amount         (s_axis_tdata[30:23]),
    .last           (s_axis_tlast),
    .out_ready      (m_axis_tready),
    .out_valid      (m_axis_tvalid),
    .verdict        (verdict),
    .finished_count (finished_count)
  );

  assign m_axis_tdata = {1'b0, finished_count, verdict};

endmodule

FILE: hdl/brsc_ctrl.sv
// brsc_ctrl: sequencer for load, request check, safety scan and commit.
// Depends on brsc_pkg; drives brsc_datapath through command/status structs.
`timescale 1ns / 1ps

module brsc_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  brsc_pkg::ctrl_status_t  st,
  output brsc_pkg::ctrl_cmd_t     cmd
);
  import brsc_pkg::*;

  localparam logic [3:0] S_IDLE         = 4'd0;
  localparam logic [3:0] S_CHECK        = 4'd1;
  localparam logic [3:0] S_CHECK_DRAIN  = 4'd2;
  localparam logic [3:0] S_CHECK_END    = 4'd3;
  localparam logic [3:0] S_SCAN_SEL     = 4'd4;
  localparam logic [3:0] S_SCAN_RD      = 4'd5;
  localparam logic [3:0] S_SCAN_DRAIN   = 4'd6;
  localparam logic [3:0] S_SCAN_END     = 4'd7;
  localparam logic [3:0] S_PASS_END     = 4'd8;
  localparam logic [3:0] S_COMMIT       = 4'd9;
  localparam logic [3:0] S_COMMIT_DRAIN = 4'd10;
  localparam logic [3:0] S_OUT          = 4'd11;

  logic [3:0]           state, state_next;
  logic [VERDICT_W-1:0] verdict, verdict_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      verdict <= VERDICT_GRANTED;
    end else begin
      state   <= state_next;
      verdict <= verdict_next;
    end
  end

  always_comb begin
    cmd          = '0;
    state_next   = state;
    verdict_next = verdict;
    in_ready     = (state == S_IDLE);
    cmd.accept   = in_valid && (state == S_IDLE);
    cmd.verdict  = verdict;
    case (state)
      S_IDLE: begin
        if (cmd.accept && st.last_req) begin
          if (st.proc_bad) begin
            verdict_next = VERDICT_EXCEEDS;
            state_next   = S_OUT;
          end else begin
            cmd.fit_init = 1'b1;
            state_next   = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        cmd.issue      = 1'b1;
        cmd.mode       = MODE_CHECK;
        cmd.row_is_req = 1'b1;
        if (st.j_last) begin
          state_next = S_CHECK_DRAIN;
        end
      end
      S_CHECK_DRAIN: begin
        state_next = S_CHECK_END;
      end
      S_CHECK_END: begin
        if (!st.fit) begin
          verdict_next = VERDICT_EXCEEDS;
          state_next   = S_OUT;
        end else begin
          cmd.scan_init  = 1'b1;
          cmd.pass_start = 1'b1;
          cmd.i_clr      = 1'b1;
          state_next     = S_SCAN_SEL;
        end
      end
      S_SCAN_SEL: begin
        // skip processes already finished in an earlier pass
        if (st.finished_i) begin
          if (st.i_last) begin
            state_next = S_PASS_END;
          end else begin
            cmd.i_inc = 1'b1;
          end
        end else begin
          cmd.fit_init = 1'b1;
          state_next   = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        cmd.issue = 1'b1;
        cmd.mode  = MODE_SCAN;
        if (st.j_last) begin
          state_next = S_SCAN_DRAIN;
        end
      end
      S_SCAN_DRAIN: begin
        state_next = S_SCAN_END;
      end
      S_SCAN_END: begin
        cmd.proc_done = 1'b1;
        if (st.i_last) begin
          state_next = S_PASS_END;
        end else begin
          cmd.i_inc  = 1'b1;
          state_next = S_SCAN_SEL;
        end
      end
      S_PASS_END: begin
        if (st.all_done) begin
          verdict_next = VERDICT_GRANTED;
          state_next   = S_COMMIT;
        end else if (!st.found) begin
          verdict_next = VERDICT_UNSAFE;
          state_next   = S_OUT;
        end else begin
          cmd.pass_start = 1'b1;
          cmd.i_clr      = 1'b1;
          state_next     = S_SCAN_SEL;
        end
      end
      S_COMMIT: begin
        cmd.issue      = 1'b1;
        cmd.mode       = MODE_COMMIT;
        cmd.row_is_req = 1'b1;
        if (st.j_last) begin
          state_next = S_COMMIT_DRAIN;
        end
      end
      S_COMMIT_DRAIN: begin
        cmd.avail_commit = 1'b1;
        state_next       = S_OUT;
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/brsc_datapath.sv
// brsc_datapath: allocation/need tables, available, request and work vectors,
// finish flags, config registers and the result register. Depends on brsc_pkg.
`timescale 1ns / 1ps

module brsc_datapath #(
  parameter int MAX_PROCESSES = 16,
  parameter int MAX_RESOURCES = 8,
  parameter int UNIT_WIDTH    = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  brsc_pkg::ctrl_cmd_t                 cmd,
  output brsc_pkg::ctrl_status_t              st,
  input  logic                                cfg_we,
  input  logic [brsc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [brsc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [brsc_pkg::FUNC_W-1:0]         func,
  input  logic [brsc_pkg::PROC_W-1:0]         process,
  input  logic [brsc_pkg::RES_W-1:0]          resource,
  input  logic [brsc_pkg::VAL_W-1:0]          alloc_value,
  input  logic [brsc_pkg::VAL_W-1:0]          max_value,
  input  logic [brsc_pkg::VAL_W-1:0]          amount,
  input  logic                                last,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [brsc_pkg::VERDICT_W-1:0]      verdict,
  output logic [brsc_pkg::COUNT_W-1:0]        finished_count
);
  import brsc_pkg::*;

  localparam int PW    = $clog2(MAX_PROCESSES);
  localparam int RW    = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int NW    = $clog2(MAX_PROCESSES + 1);
  localparam int MW    = $clog2(MAX_RESOURCES + 1);
  localparam int AW    = PW + RW;
  localparam int DEPTH = 2 ** AW;
  localparam int UW    = UNIT_WIDTH;
  localparam int WW    = UNIT_WIDTH + 4;

  // configuration
  logic [CFG_NP_W-1:0] cfg_np;
  logic [CFG_NR_W-1:0] cfg_nr;
  logic [NW-1:0]       n;
  logic [MW-1:0]       m;

  // tables and vectors
  logic [UW-1:0] alloc_mem [DEPTH];
  logic [UW-1:0] need_mem  [DEPTH];
  logic [UW-1:0] alloc_q, need_q;
  logic [UW-1:0] avail   [MAX_RESOURCES];
  logic [UW-1:0] req_buf [MAX_RESOURCES];
  logic [WW-1:0] work    [MAX_RESOURCES];
  logic [WW-1:0] sum_buf [MAX_RESOURCES];
  logic [MAX_PROCESSES-1:0] finish;

  // sequencing
  logic [PW-1:0] p_reg, i, row;
  logic [RW-1:0] j, rd_j;
  logic [AW-1:0] rd_addr;
  logic          rd_v, rd_is_p;
  logic [1:0]    rd_mode;
  logic          fit, found;
  logic [NW-1:0] count;

  // input decode
  logic          proc_ok, res_ok, is_load, is_avail, is_req;
  logic [UW-1:0] alloc_u, max_u, amount_u, need_load;
  logic [RW-1:0] res_idx;

  // read-data stage
  logic [UW-1:0] req_r, need_eff, alloc_eff;
  logic [WW-1:0] work_r, sum_sat;
  logic [WW:0]   sum_w;
  logic          fail;

  // table write port
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [UW-1:0] wr_alloc, wr_need;

  always_comb begin
    if (cfg_np == '0) begin
      n = NW'(1);
    end else if (32'(cfg_np) > MAX_PROCESSES) begin
      n = NW'(MAX_PROCESSES);
    end else begin
      n = NW'(cfg_np);
    end
    if (cfg_nr == '0) begin
      m = MW'(1);
    end else if (32'(cfg_nr) > MAX_RESOURCES) begin
      m = MW'(MAX_RESOURCES);
    end else begin
      m = MW'(cfg_nr);
    end
  end

  assign proc_ok   = 32'(process) < MAX_PROCESSES;
  assign res_ok    = 32'(resource) < MAX_RESOURCES;
  assign res_idx   = RW'(resource);
  assign alloc_u   = UW'(alloc_value);
  assign max_u     = UW'(max_value);
  assign amount_u  = UW'(amount);
  assign need_load = (max_u > alloc_u) ? max_u - alloc_u : '0;
  assign is_load   = cmd.accept && (func == FUNC_LOAD_ENTRY);
  assign is_avail  = cmd.accept && (func == FUNC_LOAD_AVAIL);
  assign is_req    = cmd.accept && (func == FUNC_REQUEST);

  assign row     = cmd.row_is_req ? p_reg : i;
  assign rd_addr = {row, j};

  // the requesting process is seen with its tentative allocation applied
  assign req_r     = req_buf[rd_j];
  assign work_r    = work[rd_j];
  assign need_eff  = rd_is_p ? need_q - req_r : need_q;
  assign alloc_eff = rd_is_p ? alloc_q + req_r : alloc_q;
  assign sum_w     = {1'b0, work_r} + (WW + 1)'(alloc_eff);
  assign sum_sat   = sum_w[WW] ? '1 : sum_w[WW-1:0];

  always_comb begin
    if (rd_mode == MODE_CHECK) begin
      fail = (req_r > need_q) || (req_r > avail[rd_j]);
    end else begin
      fail = WW'(need_eff) > work_r;
    end
  end

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = {PW'(process), res_idx};
    wr_alloc = alloc_u;
    wr_need  = need_load;
    if (is_load && proc_ok && res_ok) begin
      wr_en = 1'b1;
    end else if (rd_v && (rd_mode == MODE_COMMIT)) begin
      wr_en    = 1'b1;
      wr_addr  = {p_reg, rd_j};
      wr_alloc = alloc_q + req_r;
      wr_need  = need_q - req_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      alloc_mem[wr_addr] <= wr_alloc;
      need_mem[wr_addr]  <= wr_need;
    end
    if (cmd.issue) begin
      alloc_q <= alloc_mem[rd_addr];
      need_q  <= need_mem[rd_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_mode <= cmd.mode;
    rd_j    <= j;
    rd_is_p <= cmd.row_is_req || (i == p_reg);
    if (is_req && last) begin
      p_reg <= PW'(process);
    end
    if (rd_v && (rd_mode == MODE_SCAN)) begin
      sum_buf[rd_j] <= sum_sat;
    end
    if (is_avail && res_ok) begin
      avail[res_idx] <= amount_u;
    end
    if (cmd.avail_commit) begin
      for (int k = 0; k < MAX_RESOURCES; k++) begin
        if (k < int'(m)) begin
          avail[k] <= avail[k] - req_buf[k];
        end
      end
    end
    if (cmd.out_load) begin
      verdict        <= cmd.verdict;
      finished_count <= (cmd.verdict == VERDICT_EXCEEDS) ? '0 : COUNT_W'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_np    <= CFG_NP_RESET;
      cfg_nr    <= CFG_NR_RESET;
      req_buf   <= '{default: '0};
      work      <= '{default: '0};
      finish    <= '0;
      fit       <= 1'b0;
      found     <= 1'b0;
      count     <= '0;
      i         <= '0;
      j         <= '0;
      rd_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_NUM_PROC: cfg_np <= cfg_data[CFG_NP_W-1:0];
          CFG_NUM_RES:  cfg_nr <= cfg_data[CFG_NR_W-1:0];
          default: begin
          end
        endcase
      end

      if (cmd.out_load) begin
        req_buf <= '{default: '0};
      end else if (is_req && res_ok) begin
        req_buf[res_idx] <= amount_u;
      end

      rd_v <= cmd.issue;
      if (cmd.issue) begin
        j <= st.j_last ? '0 : j + RW'(1);
      end
      if (cmd.i_clr) begin
        i <= '0;
      end else if (cmd.i_inc) begin
        i <= i + PW'(1);
      end

      if (cmd.fit_init) begin
        fit <= 1'b1;
      end else if (rd_v && (rd_mode != MODE_COMMIT) && fail) begin
        fit <= 1'b0;
      end

      if (cmd.pass_start) begin
        found <= 1'b0;
      end

      if (cmd.scan_init) begin
        for (int k = 0; k < MAX_RESOURCES; k++) begin
          work[k] <= WW'(avail[k] - req_buf[k]);
        end
        finish <= '0;
        count  <= '0;
      end else if (cmd.proc_done && fit) begin
        for (int k = 0; k < MAX_RESOURCES; k++) begin
          if (k < int'(m)) begin
            work[k] <= sum_buf[k];
          end
        end
        finish[i] <= 1'b1;
        count     <= count + NW'(1);
        found     <= 1'b1;
      end

      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    st.last_req   = (func == FUNC_REQUEST) && last;
    st.proc_bad   = 32'(process) >= 32'(n);
    st.j_last     = MW'(j) == (m - MW'(1));
    st.i_last     = NW'(i) == (n - NW'(1));
    st.fit        = fit;
    st.found      = found;
    st.all_done   = (count == n);
    st.finished_i = finish[i];
    st.out_free   = !out_valid || out_ready;
  end

endmodule

FILE: verif/tb_bankers_request_safety_check.sv
// tb_bankers_request_safety_check: self-checking bench for the banker's request check.
// Drives table loads and multi-element requests, predicts every verdict with a local
// copy of the tables and the safety scan. Depends on brsc_pkg and the top level.
`timescale 1ns / 1ps

module tb_bankers_request_safety_check;
  import brsc_pkg::*;

  localparam int CYCLE_LIMIT  = 20_000_000;
  localparam int DRAIN_CYCLES = 64;
  localparam int IDLE_PCT     = 32;
  localparam int RANDOM_ITEMS = 700;
  localparam int NP_MAX       = 16;
  localparam int NR_MAX       = 8;
  localparam int STALL_CYCLES = 2000;
  localparam logic [12:0] WORK_CAP = 13'd4095;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam logic [1:0] ROW_ITEM   = 2'd0;
  localparam logic [1:0] ROW_SET_NP = 2'd1;
  localparam logic [1:0] ROW_SET_NR = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]    func;
    logic [PROC_W-1:0]    proc;
    logic [RES_W-1:0]     rsrc;
    logic [VAL_W-1:0]     alloc_v;
    logic [VAL_W-1:0]     max_v;
    logic [VAL_W-1:0]     amt;
    logic                 last;
    logic                 typed;
    logic [VERDICT_W-1:0] t_verdict;
    logic [COUNT_W-1:0]   t_count;
  } op_t;

  typedef struct packed {
    logic [VERDICT_W-1:0] verdict;
    logic [COUNT_W-1:0]   count;
  } outcome_t;

  typedef struct packed {
    logic [1:0] kind;
    op_t        op;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [FUNC_W-1:0]      s_axis_tuser = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // predicted block state
  logic [VAL_W-1:0] alloc_units [NP_MAX][NR_MAX];
  logic [VAL_W-1:0] need_units  [NP_MAX][NR_MAX];
  logic [VAL_W-1:0] avail_units [NR_MAX];
  logic [VAL_W-1:0] req_units   [NR_MAX];
  logic [11:0]      work_units  [NR_MAX];
  logic             done_flags  [NP_MAX];
  logic [4:0]       np_reg = CFG_NP_RESET;
  logic [3:0]       nr_reg = CFG_NR_RESET;

  op_t      send_q [$];
  outcome_t verdict_q [$];
  row_t     dir_rows [$];
  op_t      cur_op;
  outcome_t rx_want;

  int  pushed_cnt = 0;
  int  taken_cnt = 0;
  int  results_seen = 0;
  int  hold_left = 0;
  int  err_cnt = 0;
  int  cycles = 0;
  int  granted_cnt = 0;
  int  exceeds_cnt = 0;
  int  unsafe_cnt = 0;
  int  phases_run = 0;
  logic quiet = 1'b0;

  bankers_request_safety_check dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  function automatic int eff_count(input int raw, input int hi);
    if (raw == 0) return 1;
    return (raw > hi) ? hi : raw;
  endfunction

  // resource check, tentative grant, repeated safety scan, rollback when unsafe
  task automatic judge_request(input logic [PROC_W-1:0] p, output outcome_t got);
    int n, m, cnt;
    logic found, fits, over;
    logic [12:0] sum;
    n = eff_count(np_reg, NP_MAX);
    m = eff_count(nr_reg, NR_MAX);
    got.verdict = VERDICT_EXCEEDS;
    got.count = '0;
    if (int'(p) >= n) return;
    over = 1'b0;
    for (int j = 0; j < m; j++)
      if (req_units[j] > need_units[p][j] || req_units[j] > avail_units[j]) over = 1'b1;
    if (over) return;
    for (int j = 0; j < m; j++) begin
      avail_units[j] = avail_units[j] - req_units[j];
      alloc_units[p][j] = alloc_units[p][j] + req_units[j];
      need_units[p][j] = need_units[p][j] - req_units[j];
    end
    for (int i = 0; i < n; i++) done_flags[i] = 1'b0;
    for (int j = 0; j < m; j++) work_units[j] = {4'd0, avail_units[j]};
    cnt = 0;
    found = 1'b1;
    while (cnt < n && found) begin
      found = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (!done_flags[i]) begin
          fits = 1'b1;
          for (int j = 0; j < m; j++)
            if (need_units[i][j] > work_units[j]) fits = 1'b0;
          if (fits) begin
            for (int j = 0; j < m; j++) begin
              sum = {1'b0, work_units[j]} + 13'(alloc_units[i][j]);
              work_units[j] = (sum > WORK_CAP) ? WORK_CAP[11:0] : sum[11:0];
            end
            done_flags[i] = 1'b1;
            found = 1'b1;
            cnt++;
          end
        end
      end
    end
    got.count = cnt[COUNT_W-1:0];
    if (cnt == n) begin
      got.verdict = VERDICT_GRANTED;
      return;
    end
    for (int j = 0; j < m; j++) begin
      avail_units[j] = avail_units[j] + req_units[j];
      alloc_units[p][j] = alloc_units[p][j] - req_units[j];
      need_units[p][j] = need_units[p][j] + req_units[j];
    end
    got.verdict = VERDICT_UNSAFE;
  endtask

  task automatic track_accepted(input op_t o);
    outcome_t got;
    case (o.func)
      FUNC_LOAD_ENTRY: begin
        alloc_units[o.proc][o.rsrc] = o.alloc_v;
        need_units[o.proc][o.rsrc] = (o.max_v > o.alloc_v) ? o.max_v - o.alloc_v : '0;
      end
      FUNC_LOAD_AVAIL: begin
        avail_units[o.rsrc] = o.amt;
      end
      FUNC_REQUEST: begin
        req_units[o.rsrc] = o.amt;
        if (o.last) begin
          judge_request(o.proc, got);
          if (o.typed) begin
            got.verdict = o.t_verdict;
            got.count = o.t_count;
          end
          verdict_q.push_back(got);
          for (int j = 0; j < NR_MAX; j++) req_units[j] = '0;
        end
      end
      default: ;
    endcase
  endtask

  function automatic op_t mk_op(input logic [FUNC_W-1:0] f, input int p, r, av, mx, amt,
                                input logic last);
    op_t o;
    o = '0;
    o.func = f;
    o.proc = p[PROC_W-1:0];
    o.rsrc = r[RES_W-1:0];
    o.alloc_v = av[VAL_W-1:0];
    o.max_v = mx[VAL_W-1:0];
    o.amt = amt[VAL_W-1:0];
    o.last = last;
    return o;
  endfunction

  task automatic send_op(input op_t o);
    send_q.push_back(o);
    pushed_cnt++;
  endtask

  task automatic add_row(input logic [1:0] kind, input logic [FUNC_W-1:0] f,
                         input int p, r, av, mx, amt, input logic last, input logic typed,
                         input logic [VERDICT_W-1:0] v, input int c);
    row_t row;
    row.kind = kind;
    row.op = mk_op(f, p, r, av, mx, amt, last);
    row.op.typed = typed;
    row.op.t_verdict = v;
    row.op.t_count = c[COUNT_W-1:0];
    dir_rows.push_back(row);
  endtask

  // everything accepted, every verdict back, and the commit given time to finish
  task automatic settle();
    while (taken_cnt != pushed_cnt) @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [4:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_NUM_PROC) np_reg = val;
    else nr_reg = val[3:0];
  endtask

  // sender: a request is held until accepted
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        track_accepted(cur_op);
        taken_cnt++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_q.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
          cur_op = send_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {1'b0, cur_op.amt, cur_op.max_v, cur_op.alloc_v, cur_op.rsrc,
                           cur_op.proc};
          s_axis_tuser <= cur_op.func;
          s_axis_tlast <= cur_op.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each verdict, stalls at random and twice for a long stretch
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdict_q.size() == 0) begin
          $error("result with no request pending: verdict %0d finished_count %0d",
                 m_axis_tdata[VERDICT_W-1:0], m_axis_tdata[VERDICT_W+COUNT_W-1:VERDICT_W]);
          err_cnt++;
        end else begin
          rx_want = verdict_q.pop_front();
          if (m_axis_tdata[VERDICT_W-1:0] !== rx_want.verdict) begin
            $error("verdict: expected %0d, got %0d", rx_want.verdict,
                   m_axis_tdata[VERDICT_W-1:0]);
            err_cnt++;
          end
          if (m_axis_tdata[VERDICT_W+COUNT_W-1:VERDICT_W] !== rx_want.count) begin
            $error("finished_count: expected %0d, got %0d", rx_want.count,
                   m_axis_tdata[VERDICT_W+COUNT_W-1:VERDICT_W]);
            err_cnt++;
          end
          case (rx_want.verdict)
            VERDICT_GRANTED: granted_cnt++;
            VERDICT_EXCEEDS: exceeds_cnt++;
            default:         unsafe_cnt++;
          endcase
        end
        results_seen++;
        if (results_seen == 15 || results_seen == 120) hold_left = STALL_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding", cycles, verdict_q.size());
      $display("** bankers_request_safety_check: FAILED **");
      $finish;
    end
  end

  initial begin
    int n_eff, m_eff, style, k, p, r, cap, av, nd, mx, amt, phase, reqs, rand_items;
    logic [4:0] np_raw, nr_raw;
    for (int i = 0; i < NP_MAX; i++) begin
      done_flags[i] = 1'b0;
      for (int j = 0; j < NR_MAX; j++) begin
        alloc_units[i][j] = '0;
        need_units[i][j] = '0;
      end
    end
    for (int j = 0; j < NR_MAX; j++) begin
      avail_units[j] = '0;
      req_units[j] = '0;
      work_units[j] = '0;
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // every entry gets written before the first request can read it
    for (int i = 0; i < NP_MAX; i++)
      for (int j = 0; j < NR_MAX; j++)
        send_op(mk_op(FUNC_LOAD_ENTRY, i, j, 1, 3, 0, 1'b0));
    for (int j = 0; j < NR_MAX; j++)
      send_op(mk_op(FUNC_LOAD_AVAIL, 0, j, 0, 0, 10, 1'b0));

    // need 2 everywhere, 10 available: a small request lets all 16 finish
    add_row(ROW_ITEM, FUNC_REQUEST, 0, 0, 0, 0, 1, 1'b1, 1'b1, VERDICT_GRANTED, 16);
    add_row(ROW_ITEM, FUNC_REQUEST, 1, 7, 0, 0, 255, 1'b1, 1'b1, VERDICT_EXCEEDS, 0);
    // same resource sent twice, the later amount wins
    add_row(ROW_ITEM, FUNC_REQUEST, 15, 3, 0, 0, 2, 1'b0, 1'b0, VERDICT_GRANTED, 0);
    add_row(ROW_ITEM, FUNC_REQUEST, 15, 3, 0, 0, 0, 1'b1, 1'b0, VERDICT_GRANTED, 0);
    add_row(ROW_ITEM, FUNC_UNUSED, 15, 7, 255, 255, 255, 1'b1, 1'b0, VERDICT_GRANTED, 0);
    add_row(ROW_ITEM, FUNC_LOAD_AVAIL, 0, 7, 0, 0, 0, 1'b0, 1'b0, VERDICT_GRANTED, 0);
    add_row(ROW_ITEM, FUNC_REQUEST, 2, 7, 0, 0, 1, 1'b1, 1'b1, VERDICT_EXCEEDS, 0);
    // allocation above maximum leaves need at zero
    add_row(ROW_ITEM, FUNC_LOAD_ENTRY, 5, 2, 200, 100, 0, 1'b0, 1'b0, VERDICT_GRANTED, 0);
    add_row(ROW_ITEM, FUNC_REQUEST, 5, 2, 0, 0, 1, 1'b1, 1'b1, VERDICT_EXCEEDS, 0);
    add_row(ROW_ITEM, FUNC_LOAD_AVAIL, 0, 7, 0, 0, 255, 1'b0, 1'b0, VERDICT_GRANTED, 0);
    // one process that can never finish makes any request unsafe
    add_row(ROW_ITEM, FUNC_LOAD_ENTRY, 3, 0, 0, 255, 0, 1'b0, 1'b0, VERDICT_GRANTED, 0);
    add_row(ROW_ITEM, FUNC_REQUEST, 4, 1, 0, 0, 0, 1'b1, 1'b0, VERDICT_GRANTED, 0);
    add_row(ROW_ITEM, FUNC_LOAD_ENTRY, 3, 0, 1, 3, 0, 1'b0, 1'b0, VERDICT_GRANTED, 0);
    // zero process count acts as one
    add_row(ROW_SET_NP, FUNC_LOAD_ENTRY, 0, 0, 0, 0, 0, 1'b0, 1'b0, VERDICT_GRANTED, 0);
    add_row(ROW_ITEM, FUNC_REQUEST, 1, 0, 0, 0, 0, 1'b1, 1'b1, VERDICT_EXCEEDS, 0);
    add_row(ROW_ITEM, FUNC_REQUEST, 0, 0, 0, 0, 1, 1'b1, 1'b0, VERDICT_GRANTED, 0);
    // counts above range saturate (the resource count keeps four bits); an element past the resource count is ignored
    add_row(ROW_SET_NP, FUNC_LOAD_ENTRY, 0, 0, 0, 0, 31, 1'b0, 1'b0, VERDICT_GRANTED, 0);
    add_row(ROW_SET_NR, FUNC_LOAD_ENTRY, 0, 0, 0, 0, 0, 1'b0, 1'b0, VERDICT_GRANTED, 0);
    add_row(ROW_ITEM, FUNC_REQUEST, 15, 5, 0, 0, 255, 1'b1, 1'b0, VERDICT_GRANTED, 0);
    add_row(ROW_SET_NR, FUNC_LOAD_ENTRY, 0, 0, 0, 0, 31, 1'b0, 1'b0, VERDICT_GRANTED, 0);
    add_row(ROW_ITEM, FUNC_REQUEST, 6, 2, 0, 0, 1, 1'b1, 1'b0, VERDICT_GRANTED, 0);
    add_row(ROW_SET_NR, FUNC_LOAD_ENTRY, 0, 0, 0, 0, 16, 1'b0, 1'b0, VERDICT_GRANTED, 0);
    add_row(ROW_ITEM, FUNC_REQUEST, 7, 0, 0, 0, 2, 1'b1, 1'b0, VERDICT_GRANTED, 0);

    foreach (dir_rows[x]) begin
      if (dir_rows[x].kind == ROW_ITEM) begin
        send_op(dir_rows[x].op);
      end else begin
        settle();
        write_reg((dir_rows[x].kind == ROW_SET_NP) ? CFG_NUM_PROC : CFG_NUM_RES,
                  dir_rows[x].op.amt[4:0]);
      end
    end

    phase = 0;
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      case (phase)
        0: begin
          np_raw = 5'd16;
          nr_raw = 5'd8;
        end
        1: begin
          np_raw = 5'd1;
          nr_raw = 5'd1;
        end
        default: begin
          // mostly small sizes, the scan time grows with both counts
          np_raw = ($urandom_range(0, 3) != 0) ? 5'($urandom_range(1, 6))
                                               : 5'($urandom_range(0, 31));
          nr_raw = ($urandom_range(0, 3) != 0) ? 5'($urandom_range(1, 4))
                                               : 5'($urandom_range(0, 31));
        end
      endcase
      settle();
      write_reg(CFG_NUM_PROC, np_raw);
      write_reg(CFG_NUM_RES, nr_raw);
      quiet = (phase == 2);
      n_eff = eff_count(np_reg, NP_MAX);
      m_eff = eff_count(nr_reg, NR_MAX);
      style = $urandom_range(0, 3);

      for (int i = 0; i < n_eff; i++) begin
        for (int j = 0; j < m_eff; j++) begin
          case (style)
            0: begin av = $urandom_range(0, 30);    nd = $urandom_range(0, 40); end
            1: begin av = $urandom_range(0, 20);    nd = $urandom_range(0, 10); end
            2: begin av = $urandom_range(200, 255); nd = $urandom_range(0, 10); end
            default: begin av = $urandom_range(0, 255); nd = $urandom_range(0, 255); end
          endcase
          mx = (style == 3) ? $urandom_range(0, 255) : av + nd;
          if (mx > 255) mx = 255;
          send_op(mk_op(FUNC_LOAD_ENTRY, i, j, av, mx, $urandom_range(0, 255), 1'b0));
          rand_items++;
        end
      end
      for (int j = 0; j < m_eff; j++) begin
        case (style)
          0: amt = $urandom_range(0, 60);
          1: amt = $urandom_range(40, 255);
          2: amt = $urandom_range(200, 255);
          default: amt = $urandom_range(0, 255);
        endcase
        send_op(mk_op(FUNC_LOAD_AVAIL, $urandom_range(0, 15), j, $urandom_range(0, 255),
                      $urandom_range(0, 255), amt, 1'b0));
        rand_items++;
      end

      reqs = $urandom_range(8, 20);
      repeat (reqs) begin
        // amounts are drawn from the tables as they stand after the last decision
        while (taken_cnt != pushed_cnt) @(posedge clk);
        p = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, n_eff - 1);
        k = $urandom_range(1, m_eff + 1);
        for (int e = 0; e < k; e++) begin
          r = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7)
                                          : $urandom_range(0, m_eff - 1);
          cap = (need_units[p][r] < avail_units[r]) ? need_units[p][r] : avail_units[r];
          amt = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, cap);
          if ($urandom_range(0, 19) == 0) begin
            if ($urandom_range(0, 1) == 0) begin
              send_op(mk_op(FUNC_UNUSED, $urandom_range(0, 15), $urandom_range(0, 7),
                            $urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 255), 1'($urandom_range(0, 1))));
            end else begin
              send_op(mk_op(FUNC_LOAD_AVAIL, $urandom_range(0, 15), $urandom_range(0, 7),
                            0, 0, $urandom_range(0, 255), 1'b0));
              rand_items++;
            end
          end
          send_op(mk_op(FUNC_REQUEST, p, r, $urandom_range(0, 255), $urandom_range(0, 255),
                        amt, e == k - 1));
          rand_items++;
        end
      end
      phase++;
    end
    phases_run = phase;

    while (taken_cnt != pushed_cnt) @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d bus items over %0d random configurations plus directed cases, %0d cycles",
             pushed_cnt, phases_run, cycles);
    $display("verdicts: %0d granted, %0d exceeds, %0d unsafe; %0d mismatches",
             granted_cnt, exceeds_cnt, unsafe_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("** bankers_request_safety_check: PASSED **");
    end else begin
      $display("** bankers_request_safety_check: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/brsc_pkg.sv
hdl/brsc_ctrl.sv
hdl/brsc_datapath.sv
hdl/bankers_request_safety_check.sv
verif/tb_bankers_request_safety_check.sv
